>>> rtl/bdq_pkg.sv
`default_nettype none

package bdq_pkg;

    // Operation codes carried in the op field of an input transaction.
    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_LIST_FWD   = 3'd2;
    localparam logic [2:0] OP_LIST_BWD   = 3'd3;
    localparam logic [2:0] OP_REMOVE     = 3'd4;

    // Status codes of a result transaction.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] data;
        logic [1:0]         status;
        logic               last;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LIST,
        S_SCAN,
        S_RESP
    } t_state;

endpackage

`default_nettype wire

>>> rtl/bdq_five_check.sv
`default_nettype none

// Flags a 32-bit word whose truncated remainder by 10 is 5: the word must be
// non-negative and odd, and divisible by 5. Since 16 is 1 modulo 5, the
// nibble sum keeps the residue modulo 5; two more folds bring it to 0..15.
module bdq_five_check (
    input  wire logic [31:0] i_value,
    output logic             o_ends_in_five
);

    logic [6:0] nib_sum;
    logic [4:0] fold1;
    logic [4:0] fold2;
    logic       div5;

    always_comb begin
        nib_sum = '0;
        for (int i = 0; i < 8; i++) begin
            nib_sum = nib_sum + 7'(i_value[4*i +: 4]);
        end
        fold1 = 5'(nib_sum[6:4]) + 5'(nib_sum[3:0]);
        fold2 = 5'(fold1[4]) + 5'(fold1[3:0]);
        div5  = (fold2 == 5'd0) || (fold2 == 5'd5) || (fold2 == 5'd10) || (fold2 == 5'd15);
        o_ends_in_five = !i_value[31] && i_value[0] && div5;
    end

endmodule

`default_nettype wire

>>> rtl/bounded_deque_with_filter_remove_unit.sv
// Bounded double-ended queue of signed 32-bit values with an in-place filter.
// Input channel: i_in_valid / o_in_stall carry one transaction of op and value.
// Output channel: o_out_valid / i_out_stall carry result transactions of data,
// status and last; the final result caused by an input transaction has last set.
// A push, an operation on an empty queue, a push to a full queue and an unused
// op code each give one result, loaded into the output register on acceptance.
// A listing of N entries gives N results at one per cycle while the output is
// not stalled; each passes through the store's registered read, then the result register.
// A removal walks every entry, one per cycle through the store's read and
// write ports, and gives its single result once the walk has ended.
// One input transaction is worked on at a time; the next one is taken when the
// sequencer is idle and the output register is free or being emptied.
// A result held under i_out_stall stays unchanged, and while it is held the
// walk through the store pauses, so no result is lost.
// Reset (synchronous, active low) empties the queue, sets the front to zero and
// drops any pending result. The store contents are not cleared; only entries
// that have been written are ever read.
`default_nettype none

module bounded_deque_with_filter_remove_unit #(
    parameter int DEPTH = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire bdq_pkg::t_in_item i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output bdq_pkg::t_out_item     o_out_data
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // Ring position of the entry k places behind the front.
    function automatic logic [IW-1:0] slot(input logic [IW-1:0] front,
                                           input logic [CW-1:0] k);
        logic [CW:0] sum;
        sum = (CW+1)'(front) + (CW+1)'(k);
        if (sum >= (CW+1)'(DEPTH)) begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[IW-1:0];
    endfunction

    bdq_pkg::t_state r_state, n_state;

    logic [IW-1:0] r_front, n_front;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_k, n_k;       // entry index whose data sits in r_rdata
    logic [CW-1:0] r_w, n_w;       // write index of the compaction
    logic          r_dir, n_dir;   // listing runs back to front

    logic [31:0]   r_mem [DEPTH];
    logic [31:0]   r_rdata;

    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic          mem_re;
    logic [IW-1:0] mem_raddr;

    logic               r_out_valid;
    bdq_pkg::t_out_item r_out;
    logic               out_load;
    bdq_pkg::t_out_item out_item;

    logic          out_free;
    logic          in_accept;
    logic          is_push;
    logic          is_list;
    logic          is_remove;
    logic          q_empty;
    logic          q_full;
    logic          last_entry;
    logic          ends_five;
    logic [CW-1:0] k_next;
    logic [CW-1:0] list_pos;

    // Result register: the sequencer may load it when it is empty or when the
    // receiver takes its current transaction in this cycle.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == bdq_pkg::S_IDLE) && out_free);
    assign in_accept  = i_in_valid && !o_in_stall;

    assign is_push    = (i_in_data.op == bdq_pkg::OP_PUSH_FRONT)
                     || (i_in_data.op == bdq_pkg::OP_PUSH_BACK);
    assign is_list    = (i_in_data.op == bdq_pkg::OP_LIST_FWD)
                     || (i_in_data.op == bdq_pkg::OP_LIST_BWD);
    assign is_remove  = (i_in_data.op == bdq_pkg::OP_REMOVE);
    assign q_empty    = (r_count == '0);
    assign q_full     = (r_count == CW'(DEPTH));
    assign last_entry = (r_k == r_count - 1'b1);
    assign k_next     = r_k + 1'b1;
    assign list_pos   = r_dir ? (r_count - 1'b1 - k_next) : k_next;

    bdq_five_check u_five_check (
        .i_value        (r_rdata),
        .o_ends_in_five (ends_five)
    );

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bdq_pkg::S_IDLE: begin
                if (in_accept && !q_empty) begin
                    if (is_list) begin
                        n_state = bdq_pkg::S_LIST;
                    end else if (is_remove) begin
                        n_state = bdq_pkg::S_SCAN;
                    end
                end
            end
            bdq_pkg::S_LIST: begin
                if (out_free && last_entry) begin
                    n_state = bdq_pkg::S_IDLE;
                end
            end
            bdq_pkg::S_SCAN: begin
                if (last_entry) begin
                    n_state = bdq_pkg::S_RESP;
                end
            end
            bdq_pkg::S_RESP: begin
                if (out_free) begin
                    n_state = bdq_pkg::S_IDLE;
                end
            end
            default: n_state = bdq_pkg::S_IDLE;
        endcase
    end

    // Datapath, store accesses and results for each state.
    always_comb begin
        n_front   = r_front;
        n_count   = r_count;
        n_k       = r_k;
        n_w       = r_w;
        n_dir     = r_dir;
        mem_we    = 1'b0;
        mem_waddr = slot(r_front, r_w);
        mem_wdata = r_rdata;
        mem_re    = 1'b0;
        mem_raddr = slot(r_front, '0);
        out_load  = 1'b0;
        out_item  = '0;
        out_item.status = bdq_pkg::ST_OK;
        out_item.last   = 1'b1;

        unique case (r_state)
            bdq_pkg::S_IDLE: begin
                if (in_accept) begin
                    priority if (is_push) begin
                        // A push always answers at once; a full queue drops it.
                        out_load = 1'b1;
                        if (q_full) begin
                            out_item.status = bdq_pkg::ST_FULL;
                        end else begin
                            mem_we    = 1'b1;
                            mem_wdata = i_in_data.value;
                            n_count   = r_count + 1'b1;
                            if (i_in_data.op == bdq_pkg::OP_PUSH_FRONT) begin
                                n_front   = (r_front == '0) ? IW'(DEPTH - 1)
                                                            : r_front - 1'b1;
                                mem_waddr = n_front;
                            end else begin
                                mem_waddr = slot(r_front, r_count);
                            end
                        end
                    end else if (is_list || is_remove) begin
                        if (q_empty) begin
                            out_load        = 1'b1;
                            out_item.status = bdq_pkg::ST_EMPTY;
                        end else begin
                            // Fetch the first entry of the walk now, so its
                            // data is ready when the walk state begins.
                            n_k    = '0;
                            n_w    = '0;
                            n_dir  = (i_in_data.op == bdq_pkg::OP_LIST_BWD);
                            mem_re = 1'b1;
                            if (i_in_data.op == bdq_pkg::OP_LIST_BWD) begin
                                mem_raddr = slot(r_front, r_count - 1'b1);
                            end
                        end
                    end else begin
                        // Unused operation codes leave the queue alone.
                        out_load = 1'b1;
                    end
                end
            end
            bdq_pkg::S_LIST: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    out_item.data = $signed(r_rdata);
                    out_item.last = last_entry;
                    if (!last_entry) begin
                        n_k       = k_next;
                        mem_re    = 1'b1;
                        mem_raddr = slot(r_front, list_pos);
                    end
                end
            end
            bdq_pkg::S_SCAN: begin
                // Survivors are written back at the write index, which never
                // passes the read index, so no entry is overwritten before it
                // has been read.
                if (!ends_five) begin
                    mem_we = 1'b1;
                    n_w    = r_w + 1'b1;
                end
                if (last_entry) begin
                    n_count = ends_five ? r_w : r_w + 1'b1;
                end else begin
                    n_k       = k_next;
                    mem_re    = 1'b1;
                    mem_raddr = slot(r_front, k_next);
                end
            end
            bdq_pkg::S_RESP: begin
                out_load = out_free;
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bdq_pkg::S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_k         <= '0;
            r_w         <= '0;
            r_dir       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
            r_k     <= n_k;
            r_w     <= n_w;
            r_dir   <= n_dir;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= out_item;
        end
    end

    // Entry store: one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

>>> tb/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 32;

    // Op codes the block does not use. They must leave the queue alone and
    // still answer with a single plain result.
    localparam logic [2:0] OP_SPARE_5 = 3'd5;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MAX_FIVE = 32'sd2147483645;

    // Removal walks every entry of the queue, so it is the slowest single transaction.
    localparam int DRAIN_CYCLES = DEPTH + 8;
    localparam int CYCLE_LIMIT = 400000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    bdq_pkg::t_in_item  i_in_data;
    logic               o_out_valid;
    logic               i_out_stall;
    bdq_pkg::t_out_item o_out_data;

    bounded_deque_with_filter_remove_unit #(
        .DEPTH(DEPTH)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    // Shadow copy of the deque. It is advanced once per accepted input
    // transaction, and every result that transaction must produce is queued
    // in expected_results in the order the block has to emit them.
    logic signed [31:0] deque_store [DEPTH];
    logic [4:0]         front_idx;
    logic [5:0]         entry_count;
    bdq_pkg::t_out_item expected_results[$];

    bit  failed;
    bit  quiet;       // when set, neither side of the block idles or stalls
    int  items_sent;
    int  cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // A watchdog. A healthy run finishes far inside this many cycles, so
    // reaching it means the block has hung or lost results.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // The receiving side stalls with a chance of 12 in a hundred at each falling edge, except during
    // the quiet stretch, where results are taken as fast as they come.
    always @(negedge i_clk) begin
        i_out_stall <= !quiet && ($urandom_range(99) < 12);
    end

    function automatic int slot_of(int k);
        return (int'(front_idx) + k) % DEPTH;
    endfunction

    // Only non-negative values can leave a truncated remainder of five.
    function automatic bit ends_in_five(logic signed [31:0] v);
        return (v >= 0) && ((v % 10) == 5);
    endfunction

    // Number of live entries that a removal can never take away.
    function automatic int durable_entries();
        int n;
        n = 0;
        for (int k = 0; k < entry_count; k++) begin
            if (!ends_in_five(deque_store[slot_of(k)])) n++;
        end
        return n;
    endfunction

    function automatic void queue_result(logic signed [31:0] data, logic [1:0] status,
                                         logic last);
        bdq_pkg::t_out_item r;
        r.data = data;
        r.status = status;
        r.last = last;
        expected_results.push_back(r);
    endfunction

    // Applies one input transaction to the shadow deque.
    function automatic void apply_deque_op(bdq_pkg::t_in_item it);
        int w;
        int pos;
        logic signed [31:0] v;
        w = 0;
        case (it.op)
            bdq_pkg::OP_PUSH_FRONT, bdq_pkg::OP_PUSH_BACK: begin
                if (entry_count >= DEPTH) begin
                    queue_result('0, bdq_pkg::ST_FULL, 1'b1);
                end else begin
                    if (it.op == bdq_pkg::OP_PUSH_FRONT) begin
                        front_idx = 5'((int'(front_idx) + DEPTH - 1) % DEPTH);
                        deque_store[front_idx] = it.value;
                    end else begin
                        deque_store[slot_of(entry_count)] = it.value;
                    end
                    entry_count = entry_count + 6'd1;
                    queue_result('0, bdq_pkg::ST_OK, 1'b1);
                end
            end
            bdq_pkg::OP_LIST_FWD, bdq_pkg::OP_LIST_BWD: begin
                if (entry_count == 0) begin
                    queue_result('0, bdq_pkg::ST_EMPTY, 1'b1);
                end else begin
                    for (int k = 0; k < entry_count; k++) begin
                        pos = (it.op == bdq_pkg::OP_LIST_FWD)
                            ? k : (int'(entry_count) - 1 - k);
                        queue_result(deque_store[slot_of(pos)], bdq_pkg::ST_OK,
                                     (k + 1 == entry_count));
                    end
                end
            end
            bdq_pkg::OP_REMOVE: begin
                if (entry_count == 0) begin
                    queue_result('0, bdq_pkg::ST_EMPTY, 1'b1);
                end else begin
                    // Compact in place: survivors slide towards the front and
                    // keep their order; the front index itself stays put.
                    for (int k = 0; k < entry_count; k++) begin
                        v = deque_store[slot_of(k)];
                        if (!ends_in_five(v)) begin
                            deque_store[slot_of(w)] = v;
                            w++;
                        end
                    end
                    entry_count = 6'(w);
                    queue_result('0, bdq_pkg::ST_OK, 1'b1);
                end
            end
            default: queue_result('0, bdq_pkg::ST_OK, 1'b1);
        endcase
    endfunction

    // Presents one transaction at the falling edge and holds it until the
    // block takes it. A random idle gap may come first. Valid stays high from
    // one transaction straight into the next when no gap is drawn, so it is
    // only ever assigned once per time step.
    task automatic send_item(logic [2:0] op, logic signed [31:0] value);
        bdq_pkg::t_in_item it;
        it.op = op;
        it.value = value;
        while (!quiet && $urandom_range(99) < 12) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (o_in_stall);
        apply_deque_op(it);
        items_sent++;
    endtask

    // Result checker. Each result taken by the receiving side is compared
    // with the oldest outstanding expectation, field by field.
    bdq_pkg::t_out_item want;
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: data %0d status %0d last %0d",
                       o_out_data.data, o_out_data.status, o_out_data.last);
                failed = 1'b1;
            end else begin
                want = expected_results.pop_front();
                if (o_out_data.data !== want.data) begin
                    $error("data mismatch: expected %0d, got %0d",
                           want.data, o_out_data.data);
                    failed = 1'b1;
                end
                if (o_out_data.status !== want.status) begin
                    $error("status mismatch: expected %0d, got %0d",
                           want.status, o_out_data.status);
                    failed = 1'b1;
                end
                if (o_out_data.last !== want.last) begin
                    $error("last mismatch: expected %0d, got %0d",
                           want.last, o_out_data.last);
                    failed = 1'b1;
                end
            end
        end
    end

    // A value that a later removal will clear: non-negative and ending in 5.
    function automatic logic signed [31:0] five_value();
        case ($urandom_range(9))
            0: return 32'sd5;
            1: return MAX_FIVE;
            default: return 32'(10 * $urandom_range(214748364) + 5);
        endcase
    endfunction

    // Every value that does not end in 5 stays in the queue for good, since
    // removal is the only way entries leave. Such values are therefore kept
    // rare, so that the queue keeps room to grow and shrink for the whole run.
    function automatic logic signed [31:0] push_value();
        if (durable_entries() < 20 && $urandom_range(99) < 10) return $urandom();
        return five_value();
    endfunction

    // Either push code, picked at random.
    function automatic logic [2:0] any_push();
        return $urandom_range(1) ? bdq_pkg::OP_PUSH_FRONT : bdq_pkg::OP_PUSH_BACK;
    endfunction

    // Listing, removal and spare op codes on a queue that has never held
    // anything: each must answer with a single empty or plain result.
    task automatic test_empty_queue();
        send_item(bdq_pkg::OP_LIST_FWD, 32'sd0);
        send_item(bdq_pkg::OP_LIST_BWD, INT_MAX);
        send_item(bdq_pkg::OP_REMOVE, INT_MIN);
        for (int op = OP_SPARE_5; op <= OP_SPARE_7; op++) begin
            send_item(3'(op), $urandom());
        end
    endtask

    // Removing the only element, and removing every element of a longer
    // queue, must both leave it empty rather than in some broken state.
    task automatic test_remove_to_empty();
        send_item(bdq_pkg::OP_PUSH_BACK, 32'sd5);
        send_item(bdq_pkg::OP_REMOVE, 32'sd0);
        send_item(bdq_pkg::OP_LIST_FWD, 32'sd0);
        send_item(bdq_pkg::OP_PUSH_FRONT, 32'sd25);
        send_item(bdq_pkg::OP_PUSH_BACK, MAX_FIVE);
        send_item(bdq_pkg::OP_REMOVE, 32'sd0);
        send_item(bdq_pkg::OP_LIST_BWD, 32'sd0);
    endtask

    // Extremes of the value field at both ends. Negative values ending in 5
    // must survive a removal; positive ones must go.
    task automatic test_edge_values();
        send_item(bdq_pkg::OP_PUSH_FRONT, INT_MIN);
        send_item(bdq_pkg::OP_PUSH_BACK, INT_MAX);
        send_item(bdq_pkg::OP_PUSH_FRONT, -32'sd5);
        send_item(bdq_pkg::OP_PUSH_BACK, 32'sd15);
        send_item(bdq_pkg::OP_PUSH_FRONT, 32'sd0);
        send_item(bdq_pkg::OP_PUSH_BACK, -32'sd15);
        send_item(bdq_pkg::OP_LIST_FWD, 32'sd0);
        send_item(bdq_pkg::OP_LIST_BWD, 32'sd0);
        send_item(bdq_pkg::OP_REMOVE, 32'sd0);
        send_item(bdq_pkg::OP_LIST_FWD, 32'sd0);
        send_item(bdq_pkg::OP_LIST_BWD, 32'sd0);
    endtask

    // Fills the queue to capacity, then pushes more: those transactions must
    // be dropped with a full status. The dropped pushes carry fully random
    // values, which is also where the sign bit gets plenty of exercise.
    task automatic fill_and_overflow();
        while (entry_count < DEPTH) begin
            send_item(any_push(), five_value());
        end
        repeat ($urandom_range(1, 3)) begin
            send_item(any_push(), $urandom());
        end
        send_item($urandom_range(1) ? bdq_pkg::OP_LIST_FWD : bdq_pkg::OP_LIST_BWD,
                  $urandom());
        send_item(bdq_pkg::OP_REMOVE, $urandom());
    endtask

    // Random traffic built from short well-formed sequences: bursts of
    // pushes at either end, listings in both directions, removals, and now
    // and then a fill to capacity or a spare op code as noise.
    task automatic run_random_mix(int n);
        int stop_at;
        stop_at = items_sent + n;
        while (items_sent < stop_at) begin
            case ($urandom_range(11))
                0, 1, 2, 3: begin
                    repeat ($urandom_range(1, 6)) begin
                        send_item(any_push(), push_value());
                    end
                end
                4, 5: send_item(bdq_pkg::OP_LIST_FWD, $urandom());
                6, 7: send_item(bdq_pkg::OP_LIST_BWD, $urandom());
                8, 9: send_item(bdq_pkg::OP_REMOVE, $urandom());
                10: fill_and_overflow();
                default: send_item(3'($urandom_range(OP_SPARE_5, OP_SPARE_7)), $urandom());
            endcase
        end
    endtask

    // The same traffic with neither side ever idling, so that back-to-back
    // transactions and results are seen at full rate.
    task automatic test_full_rate(int n);
        quiet = 1'b1;
        run_random_mix(n);
        quiet = 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        failed = 1'b0;
        quiet = 1'b0;
        items_sent = 0;
        cycle_count = 0;
        front_idx = '0;
        entry_count = '0;
        foreach (deque_store[k]) deque_store[k] = '0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_queue();
        test_remove_to_empty();
        test_edge_values();
        fill_and_overflow();
        run_random_mix(180);
        test_full_rate(100);
        run_random_mix(150);

        @(negedge i_clk);
        i_in_valid <= 1'b0;

        // Let every outstanding result arrive, then give the block time to
        // show anything it should not send.
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (!failed) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
